[rtl/core/pchist_pkg.sv]
`default_nettype none

package pchist_pkg;

    // Stream field widths, fixed by the item layout
    localparam int SYMBOL_W     = 8;
    localparam int WEIGHT_W     = 24;
    localparam int OUT_COUNT_W  = 32;

    // tdata of the input side: symbol, weight
    localparam int IN_DATA_W    = SYMBOL_W + WEIGHT_W;
    // tdata of the output side: read_symbol, start_count, end_count
    localparam int OUT_DATA_W   = SYMBOL_W + 2 * OUT_COUNT_W;

    // Configuration port
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int MASK_W       = CFG_DATA_W * (2 ** CFG_INDEX_W);

    // Item kinds carried in tuser
    localparam logic KIND_ACCUM = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_3 = 2'd3;

endpackage

`default_nettype wire

[rtl/core/pchist_ram.sv]
`default_nettype none

module pchist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old contents when the same entry is written in that cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/positional_consonant_histogram_core.sv]
`default_nettype none

// Channel     Dir  Handshake                      Payload
// s_axis      in   s_axis_tvalid / s_axis_tready  tdata: symbol, weight; tlast: syllable_end;
//                                                 tuser: kind
// m_axis      out  m_axis_tvalid / m_axis_tready  tdata: read_symbol, start_count, end_count
// cfg         in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data (consonant masks)
//
// One accumulate item per cycle while s_axis_tready is high: each consonant item does one
// read-modify-write of the count memories, read on accept, add and write back the next cycle,
// with a bypass when the next item hits the same entry. A read result passes the update stage
// and the output register to m_axis; a run of reads is slower, as s_axis_tready drops while a
// read meets a full output register. After reset the count memories are swept to zero with
// s_axis_tready low. A stalled output buffers two results, then holds s_axis_tready low.

module positional_consonant_histogram_core #(
    parameter int SYMBOL_BITS = 8,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [7:0] symbol, [31:8] weight
    input  wire logic [pchist_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire logic                                s_axis_tlast,
    // [0] kind
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [7:0] read_symbol, [39:8] start_count, [71:40] end_count
    output logic      [pchist_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pchist_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [pchist_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import pchist_pkg::*;

    localparam int DEPTH    = 2 ** SYMBOL_BITS;
    localparam int SUM_BITS = ((COUNT_BITS > WEIGHT_W) ? COUNT_BITS : WEIGHT_W) + 1;

    // Configuration
    logic [MASK_W-1:0] r_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MASK_0: r_mask[0*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_MASK_1: r_mask[1*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_MASK_2: r_mask[2*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_MASK_3: r_mask[3*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                default:    r_mask <= r_mask;
            endcase
        end
    end

    // Clearing sweep
    logic                   r_clr_busy;
    logic [SYMBOL_BITS-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Accept stage: classify the symbol and update the syllable state
    logic                   in_accept;
    logic [SYMBOL_BITS-1:0] in_sym;
    logic [SYMBOL_W-1:0]    in_code;
    logic [WEIGHT_W-1:0]    in_weight;
    logic                   in_accum;
    logic                   in_cons;
    logic                   r_vowel;

    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign in_sym    = s_axis_tdata[SYMBOL_BITS-1:0];
    assign in_code   = SYMBOL_W'(in_sym);
    assign in_weight = s_axis_tdata[SYMBOL_W +: WEIGHT_W];
    assign in_accum  = (s_axis_tuser == KIND_ACCUM);
    assign in_cons   = r_mask[in_code];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vowel <= 1'b0;
        end else if (in_accept && in_accum) begin
            r_vowel <= (r_vowel | ~in_cons) & ~s_axis_tlast;
        end
    end

    // Update stage registers
    logic                   r_s1_valid;
    logic                   r_s1_rd;
    logic                   r_s1_wr_start;
    logic                   r_s1_wr_end;
    logic [SYMBOL_BITS-1:0] r_s1_sym;
    logic [WEIGHT_W-1:0]    r_s1_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_s1_rd       <= 1'b0;
            r_s1_wr_start <= 1'b0;
            r_s1_wr_end   <= 1'b0;
        end else begin
            r_s1_valid    <= in_accept;
            r_s1_rd       <= in_accept & ~in_accum;
            r_s1_wr_start <= in_accept & in_accum & in_cons & ~r_vowel;
            r_s1_wr_end   <= in_accept & in_accum & in_cons & r_vowel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sym    <= in_sym;
            r_s1_weight <= in_weight;
        end
    end

    // Memories
    logic [COUNT_BITS-1:0]  start_rdata;
    logic [COUNT_BITS-1:0]  end_rdata;
    logic                   start_we;
    logic                   end_we;
    logic [SYMBOL_BITS-1:0] wr_addr;
    logic [COUNT_BITS-1:0]  wr_data;
    logic [COUNT_BITS-1:0]  upd_count;

    assign start_we = r_clr_busy | (r_s1_valid & r_s1_wr_start);
    assign end_we   = r_clr_busy | (r_s1_valid & r_s1_wr_end);
    assign wr_addr  = r_clr_busy ? r_clr_addr : r_s1_sym;
    assign wr_data  = r_clr_busy ? '0 : upd_count;

    pchist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (start_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (in_accept),
        .i_raddr (in_sym),
        .o_rdata (start_rdata)
    );

    pchist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (end_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (in_accept),
        .i_raddr (in_sym),
        .o_rdata (end_rdata)
    );

    // Bypass: the read issued with an accept misses the write retiring at that edge
    logic                  r_fwd_start;
    logic                  r_fwd_end;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic                  fwd_hit;

    assign fwd_hit = r_s1_valid & (r_s1_sym == in_sym);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_start <= 1'b0;
            r_fwd_end   <= 1'b0;
        end else if (in_accept) begin
            r_fwd_start <= fwd_hit & r_s1_wr_start;
            r_fwd_end   <= fwd_hit & r_s1_wr_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_data <= upd_count;
        end
    end

    // Saturating add
    logic [COUNT_BITS-1:0] cur_start;
    logic [COUNT_BITS-1:0] cur_end;
    logic [COUNT_BITS-1:0] cur_sel;
    logic [SUM_BITS-1:0]   sum;
    logic [SUM_BITS-1:0]   count_max;

    assign cur_start = r_fwd_start ? r_fwd_data : start_rdata;
    assign cur_end   = r_fwd_end ? r_fwd_data : end_rdata;
    assign cur_sel   = r_s1_wr_start ? cur_start : cur_end;
    assign sum       = SUM_BITS'(cur_sel) + SUM_BITS'(r_s1_weight);
    assign count_max = SUM_BITS'({COUNT_BITS{1'b1}});
    assign upd_count = (sum > count_max) ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

    // Result assembly
    logic [COUNT_BITS+OUT_COUNT_W-1:0] start_ext;
    logic [COUNT_BITS+OUT_COUNT_W-1:0] end_ext;
    logic [OUT_DATA_W-1:0]             result;
    logic                              load;

    assign start_ext = {{OUT_COUNT_W{1'b0}}, cur_start};
    assign end_ext   = {{OUT_COUNT_W{1'b0}}, cur_end};
    assign result    = {end_ext[OUT_COUNT_W-1:0], start_ext[OUT_COUNT_W-1:0],
                        SYMBOL_W'(r_s1_sym)};
    assign load      = r_s1_valid & r_s1_rd;

    // Output register with one skid entry
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_skid_valid;
    logic [OUT_DATA_W-1:0] r_skid_data;
    logic                  out_take;

    assign out_take = r_out_valid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= load;
            end else begin
                r_out_valid <= load;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= load;
        end else if (load) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                if (load) begin
                    r_skid_data <= result;
                end
            end else if (load) begin
                r_out_data <= result;
            end
        end else if (!r_out_valid) begin
            if (load) begin
                r_out_data <= result;
            end
        end else if (load) begin
            r_skid_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Hold off while sweeping, or when a pending read could find no buffer slot
    assign s_axis_tready = ~r_clr_busy & ~r_skid_valid & ~(load & r_out_valid);

endmodule

`default_nettype wire
